>>> design/rssm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssm_pkg: shared types and constants
// Job and response formats, chain control and time widths used by the
// release-sorted makespan block.
// ----------------------------------------------------------------------------
package rssm_pkg;

   localparam int MAX_JOBS = 64;
   localparam int SPAN_W   = 24;
   localparam logic [SPAN_W-1:0] SPAN_MAX = {SPAN_W{1'b1}};

   // finish + delivery never exceeds (MAX_JOBS + 2) * 2^16; keep at least one
   // bit above the span width so saturation can be detected
   localparam int TIME_NAT = 16 + $clog2(MAX_JOBS + 2);
   localparam int TIME_W   = (TIME_NAT > SPAN_W) ? TIME_NAT : SPAN_W + 1;

   typedef struct packed {
      logic [15:0] release_time;
      logic [15:0] processing_time;
      logic [15:0] delivery_time;
      logic        last_job;
   } req_type;

   typedef struct packed {
      logic [SPAN_W-1:0] makespan;
      logic              overflowed;
   } rsp_type;

   typedef struct packed {
      logic [15:0] rel;
      logic [15:0] proc;
      logic [15:0] del;
   } job_type;

   typedef struct packed {
      logic insert;   // place the broadcast job in sorted position
      logic shift;    // move every job one cell toward the head
   } chain_ctl_type;

endpackage

>>> design/release_sorted_schedule_makespan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// release_sorted_schedule_makespan: makespan of a release-sorted job set
// Sorts jobs by release time in a cell chain and reports the one-machine
// makespan (max finish + delivery) when the last job of a set arrives.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_ready carry one job request per accepted cycle. A job
//   is inserted into the sorted chain in the cycle it is accepted, so jobs
//   stream in at one per cycle outside the scan. A job arriving with the
//   chain full (MAX_JOBS stored) is dropped and the set reports overflowed.
//   A request with last_job set closes the set: the chain then shifts its
//   jobs, head first, into a two-stage schedule accumulator, one job per
//   cycle. The response is registered once the chain and the accumulator
//   have drained.
//   rsp_valid/rsp_ready carry the response; it is held in an output
//   register. While it waits for the receiver, non-last jobs of the next
//   set are still accepted; a last job waits until the response is taken.
//   Makespan saturates at 2^24-1 with overflowed set.
//   Synchronous reset empties the chain and drops any pending response.
// ----------------------------------------------------------------------------
module release_sorted_schedule_makespan (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rssm_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rssm_pkg::rsp_type rsp_payload
);

   localparam int N  = rssm_pkg::MAX_JOBS;
   localparam int TW = rssm_pkg::TIME_W;

   localparam logic [1:0] ST_LOAD = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]              state_ff, state_in;
   logic                    cap_ff, cap_in;
   rssm_pkg::rsp_type       rsp_ff, rsp_in;

   rssm_pkg::chain_ctl_type ctl;
   rssm_pkg::job_type       new_job;
   rssm_pkg::job_type       cell_job [N];
   logic [N-1:0]            cell_vld;
   logic [N-1:0]            cell_ins;

   logic                    accept;
   logic                    full;
   logic                    feed;
   logic                    end_scan;
   logic                    busy;
   logic [TW-1:0]           best;
   logic                    sat;

   assign new_job.rel  = req_payload.release_time;
   assign new_job.proc = req_payload.processing_time;
   assign new_job.del  = req_payload.delivery_time;

   assign req_ready = (state_ff == ST_LOAD) ||
                      ((state_ff == ST_DONE) && !req_payload.last_job);
   assign accept    = req_valid && req_ready;
   assign full      = cell_vld[N-1];
   assign feed      = (state_ff == ST_SCAN) && cell_vld[0];
   assign end_scan  = (state_ff == ST_SCAN) && !cell_vld[0] && !busy;

   assign ctl.insert = accept && !full;
   assign ctl.shift  = feed;

   for (genvar i = 0; i < N; i++) begin : g_cell
      rssm_pkg::job_type left_job;
      logic              left_valid;
      logic              left_ins;
      rssm_pkg::job_type right_job;
      logic              right_valid;

      if (i == 0) begin : g_head
         assign left_job   = new_job;
         assign left_valid = 1'b0;
         assign left_ins   = 1'b0;
      end else begin : g_body
         assign left_job   = cell_job[i-1];
         assign left_valid = cell_vld[i-1];
         assign left_ins   = cell_ins[i-1];
      end

      if (i == N - 1) begin : g_tail
         assign right_job   = new_job;
         assign right_valid = 1'b0;
      end else begin : g_mid
         assign right_job   = cell_job[i+1];
         assign right_valid = cell_vld[i+1];
      end

      rssm_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .new_job     (new_job),
         .left_job    (left_job),
         .left_valid  (left_valid),
         .left_ins    (left_ins),
         .right_job   (right_job),
         .right_valid (right_valid),
         .job         (cell_job[i]),
         .valid       (cell_vld[i]),
         .ins         (cell_ins[i])
      );
   end

   rssm_sched u_sched (
      .clock (clock),
      .reset (reset),
      .feed  (feed),
      .job   (cell_job[0]),
      .clear (end_scan),
      .busy  (busy),
      .best  (best)
   );

   assign sat = best > TW'(rssm_pkg::SPAN_MAX);

   always_comb begin
      state_in = state_ff;
      cap_in   = cap_ff;
      rsp_in   = rsp_ff;
      if (accept && full) begin
         cap_in = 1'b1;
      end
      case (state_ff)
         ST_LOAD: begin
            if (accept && req_payload.last_job) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (end_scan) begin
               rsp_in.makespan   = sat ? rssm_pkg::SPAN_MAX
                                       : best[rssm_pkg::SPAN_W-1:0];
               rsp_in.overflowed = sat || cap_ff;
               cap_in            = 1'b0;
               state_in          = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_ready) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cap_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cap_ff   <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = (state_ff == ST_DONE);
   assign rsp_payload = rsp_ff;

   // stored jobs always occupy a contiguous run from the head cell
   a_chain_packed: assert property (@(posedge clock) disable iff (reset)
      (cell_vld & (cell_vld + 1'b1)) == '0)
      else $error("chain holds a gap");

   a_scan_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !req_ready)
      else $error("request accepted during scan");

   a_empty_at_end: assert property (@(posedge clock) disable iff (reset)
      end_scan |-> (cell_vld == '0))
      else $error("scan finished with jobs left in chain");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      end_scan |=> rsp_valid)
      else $error("no response after scan");

endmodule

>>> design/rssm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssm_cell: one slot of the sorted job chain
// Holds one job. On insert it either keeps its job, takes the new job or
// takes its left neighbor's job; on shift it takes its right neighbor's job.
// ----------------------------------------------------------------------------
module rssm_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  rssm_pkg::chain_ctl_type ctl,
   input  rssm_pkg::job_type      new_job,
   input  rssm_pkg::job_type      left_job,
   input  logic                   left_valid,
   input  logic                   left_ins,
   input  rssm_pkg::job_type      right_job,
   input  logic                   right_valid,
   output rssm_pkg::job_type      job,
   output logic                   valid,
   output logic                   ins
);

   rssm_pkg::job_type job_ff, job_in;
   logic              valid_ff, valid_in;

   // strict compare keeps equal release times in arrival order
   assign ins = !valid_ff || (job_ff.rel > new_job.rel);

   always_comb begin
      job_in   = job_ff;
      valid_in = valid_ff;
      if (ctl.insert && ins) begin
         if (left_ins) begin
            job_in   = left_job;
            valid_in = left_valid;
         end else begin
            job_in   = new_job;
            valid_in = 1'b1;
         end
      end else if (ctl.shift) begin
         job_in   = right_job;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   assign job   = job_ff;
   assign valid = valid_ff;

endmodule

>>> design/rssm_sched.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssm_sched: single-machine schedule accumulator
// Takes jobs in release order; stage 1 advances machine time, stage 2 adds
// delivery time and tracks the largest completion.
// ----------------------------------------------------------------------------
module rssm_sched (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        feed,
   input  rssm_pkg::job_type           job,
   input  logic                        clear,
   output logic                        busy,
   output logic [rssm_pkg::TIME_W-1:0] best
);

   localparam int TW = rssm_pkg::TIME_W;

   logic [TW-1:0] now_ff, now_in;
   logic [TW-1:0] best_ff, best_in;
   logic [15:0]   del_ff;
   logic          v1_ff;
   logic [TW-1:0] rel_ext;
   logic [TW-1:0] start;
   logic [TW-1:0] done;

   assign rel_ext = TW'(job.rel);
   assign start   = (rel_ext > now_ff) ? rel_ext : now_ff;
   assign now_in  = start + TW'(job.proc);
   assign done    = now_ff + TW'(del_ff);
   assign best_in = (v1_ff && (done > best_ff)) ? done : best_ff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         now_ff  <= '0;
         best_ff <= '0;
         v1_ff   <= 1'b0;
      end else begin
         if (feed) begin
            now_ff <= now_in;
         end
         v1_ff   <= feed;
         best_ff <= best_in;
      end
   end

   always_ff @(posedge clock) begin
      if (feed) begin
         del_ff <= job.del;
      end
   end

   assign busy = v1_ff;
   assign best = best_ff;

endmodule

>>> tb/tb_release_sorted_schedule_makespan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_release_sorted_schedule_makespan: self-checking bench for the makespan block
// Streams job sets through the request channel and predicts each set's
// makespan from a stably sorted copy of the jobs. Both channels idle in
// random bursts, and some sets overrun the job store. Responses are
// checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_release_sorted_schedule_makespan;

   localparam int QUIET_LIMIT = 4000;
   localparam int JOB_TARGET  = 1000;
   localparam int CALM_AFTER  = 850;

   class makespan_scoreboard;
      rssm_pkg::job_type held_jobs[$];
      bit                dropped;
      rssm_pkg::rsp_type pending_spans[$];
      int                errors;

      function int pending();
         return pending_spans.size();
      endfunction

      function rssm_pkg::rsp_type schedule_makespan();
         longint unsigned machine_time;
         longint unsigned delivered;
         longint unsigned best;
         rssm_pkg::rsp_type res;
         machine_time = 0;
         best = 0;
         foreach (held_jobs[k]) begin
            if (held_jobs[k].rel > machine_time) machine_time = held_jobs[k].rel;
            machine_time += held_jobs[k].proc;
            delivered = machine_time + held_jobs[k].del;
            if (delivered > best) best = delivered;
         end
         res.overflowed = dropped;
         if (best > rssm_pkg::SPAN_MAX) begin
            res.makespan   = rssm_pkg::SPAN_MAX;
            res.overflowed = 1'b1;
         end else begin
            res.makespan = best[rssm_pkg::SPAN_W-1:0];
         end
         return res;
      endfunction

      function void note_job(rssm_pkg::req_type r);
         rssm_pkg::job_type j;
         int pos;
         j.rel  = r.release_time;
         j.proc = r.processing_time;
         j.del  = r.delivery_time;
         if (held_jobs.size() >= rssm_pkg::MAX_JOBS) begin
            dropped = 1'b1;
         end else begin
            // equal release times stay in arrival order
            pos = held_jobs.size();
            while (pos > 0 && held_jobs[pos-1].rel > j.rel) pos--;
            held_jobs.insert(pos, j);
         end
         if (r.last_job) begin
            pending_spans.insert(pending_spans.size(), schedule_makespan());
            held_jobs.delete();
            dropped = 1'b0;
         end
      endfunction

      function void report(string what, rssm_pkg::rsp_type want, rssm_pkg::rsp_type got);
         errors++;
         if (errors <= 10)
            $display("%s: expected makespan %0d overflowed %0b, got makespan %0d overflowed %0b",
                     what, want.makespan, want.overflowed, got.makespan, got.overflowed);
      endfunction

      function void check_result(rssm_pkg::rsp_type got);
         rssm_pkg::rsp_type want;
         if (pending_spans.size() == 0) begin
            report("response with nothing pending", '0, got);
            return;
         end
         want = pending_spans.pop_front();
         if (got.makespan !== want.makespan || got.overflowed !== want.overflowed)
            report("makespan mismatch", want, got);
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   rssm_pkg::req_type req_payload;
   logic              rsp_valid;
   logic              rsp_ready;
   rssm_pkg::rsp_type rsp_payload;

   makespan_scoreboard sb = new();
   int gap_pct;
   int jobs_sent;
   int quiet_cycles;
   int ready_hold;

   release_sorted_schedule_makespan dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver stalls in random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         ready_hold <= 0;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         rsp_ready  <= 1'b0;
         ready_hold <= $urandom_range(1, 14) - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_payload);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("release_sorted_schedule_makespan verification failed");
      $finish;
   end

   function automatic rssm_pkg::req_type job_of(logic [15:0] r, logic [15:0] p,
                                                logic [15:0] d, logic last);
      rssm_pkg::req_type j;
      j.release_time    = r;
      j.processing_time = p;
      j.delivery_time   = d;
      j.last_job        = last;
      return j;
   endfunction

   function automatic logic [15:0] extreme16();
      case ($urandom_range(0, 2))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic rssm_pkg::req_type draw_job(int mode, logic last);
      rssm_pkg::req_type j;
      j = job_of(16'($urandom), 16'($urandom), 16'($urandom), last);
      case (mode)
         1: j.release_time = 16'($urandom_range(0, 3) * 1000);   // many ties
         2: j.release_time = 16'($urandom_range(0, 255));        // machine stays busy
         3: j = job_of(extreme16(), extreme16(), extreme16(), last);
         default: ;
      endcase
      return j;
   endfunction

   task automatic send_job(input rssm_pkg::req_type job);
      req_valid   <= 1'b1;
      req_payload <= job;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_job(job);
      jobs_sent++;
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   task automatic send_set(int size, int mode);
      for (int k = 0; k < size; k++) send_job(draw_job(mode, k == size - 1));
   endtask

   initial begin
      int set_idx;
      int size;
      req_valid   <= 1'b0;
      req_payload <= '0;
      reset       <= 1'b1;
      gap_pct   = 30;
      jobs_sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // single-job sets at both extremes
      send_job(job_of(16'h0000, 16'h0000, 16'h0000, 1'b1));
      send_job(job_of(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
      // arrivals in descending release order
      send_job(job_of(16'd300, 16'd10, 16'd5, 1'b0));
      send_job(job_of(16'd200, 16'd50, 16'd0, 1'b0));
      send_job(job_of(16'd100, 16'd20, 16'd400, 1'b0));
      send_job(job_of(16'd0, 16'd7, 16'd1, 1'b1));
      // equal releases: arrival order decides the schedule
      send_job(job_of(16'd5, 16'd100, 16'd0, 1'b0));
      send_job(job_of(16'd5, 16'd1, 16'd300, 1'b0));
      send_job(job_of(16'd5, 16'd40, 16'd2, 1'b0));
      send_job(job_of(16'd5, 16'd0, 16'hFFFF, 1'b1));
      // later releases wait on a busy machine, large values
      send_job(job_of(16'hFFFF, 16'h0000, 16'h0000, 1'b0));
      send_job(job_of(16'h8000, 16'hFFFF, 16'h7FFF, 1'b0));
      send_job(job_of(16'h0001, 16'hFFFF, 16'hFFFF, 1'b1));

      set_idx = 0;
      while (jobs_sent < JOB_TARGET) begin
         if (jobs_sent > CALM_AFTER || set_idx % 7 == 0) begin
            gap_pct = 0;
         end else begin
            case ($urandom_range(0, 2))
               0: gap_pct = 10;
               1: gap_pct = 30;
               default: gap_pct = 60;
            endcase
         end
         // full store: forced exactly full once, forced overrun (last job dropped) once
         if (set_idx == 10) begin
            size = rssm_pkg::MAX_JOBS;
         end else if (set_idx == 40) begin
            size = $urandom_range(rssm_pkg::MAX_JOBS + 1, rssm_pkg::MAX_JOBS + 6);
         end else begin
            case ($urandom_range(0, 19))
               0: size = $urandom_range(rssm_pkg::MAX_JOBS - 4, rssm_pkg::MAX_JOBS + 6);
               1, 2, 3: size = $urandom_range(9, 40);
               default: size = $urandom_range(1, 8);
            endcase
         end
         send_set(size, $urandom_range(0, 3));
         set_idx++;
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (rssm_pkg::MAX_JOBS + 20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("release_sorted_schedule_makespan verification clean");
      else
         $display("release_sorted_schedule_makespan verification failed");
      $finish;
   end

endmodule
